>>> hw/rtl/utg_pkg.sv
// Package for the UTF-8 to glyph index core: queue entry type, constants
// and the glyph range table. No dependencies.
package utg_pkg;

    localparam int CP_W       = 21;
    localparam int SLOT_W     = 12;
    localparam int NUM_RANGES = 15;
    localparam int RANGE_IW   = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [SLOT_W-1:0] QMARK_SLOT     = 12'd31;

    // Lead byte class masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // One decoded codepoint waiting for the glyph lookup
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            malformed;
        logic            eot;
        logic            last;
    } dec_entry_t;

    // First codepoint of each range
    function automatic logic [CP_W-1:0] range_first(input logic [RANGE_IW-1:0] idx);
        logic [CP_W-1:0] v;
        case (idx)
            4'd0:    v = 21'h000020;
            4'd1:    v = 21'h002000;
            4'd2:    v = 21'h002070;
            4'd3:    v = 21'h0020A0;
            4'd4:    v = 21'h002100;
            4'd5:    v = 21'h002150;
            4'd6:    v = 21'h002190;
            4'd7:    v = 21'h002200;
            4'd8:    v = 21'h002300;
            4'd9:    v = 21'h002500;
            4'd10:   v = 21'h002580;
            4'd11:   v = 21'h0025A0;
            4'd12:   v = 21'h002600;
            4'd13:   v = 21'h002700;
            4'd14:   v = 21'h002B00;
            default: v = '0;
        endcase
        return v;
    endfunction

    // One past the last codepoint of each range
    function automatic logic [CP_W-1:0] range_end(input logic [RANGE_IW-1:0] idx);
        logic [CP_W-1:0] v;
        case (idx)
            4'd0:    v = 21'h000100;
            4'd1:    v = 21'h002070;
            4'd2:    v = 21'h0020A0;
            4'd3:    v = 21'h0020D0;
            4'd4:    v = 21'h002150;
            4'd5:    v = 21'h002190;
            4'd6:    v = 21'h002200;
            4'd7:    v = 21'h002300;
            4'd8:    v = 21'h002400;
            4'd9:    v = 21'h002580;
            4'd10:   v = 21'h0025A0;
            4'd11:   v = 21'h002600;
            4'd12:   v = 21'h002700;
            4'd13:   v = 21'h0027C0;
            4'd14:   v = 21'h002C00;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Slot of the first glyph of each range in the packed table
    function automatic logic [SLOT_W-1:0] range_base(input logic [RANGE_IW-1:0] idx);
        logic [SLOT_W-1:0] v;
        case (idx)
            4'd0:    v = 12'd0;
            4'd1:    v = 12'd224;
            4'd2:    v = 12'd336;
            4'd3:    v = 12'd384;
            4'd4:    v = 12'd432;
            4'd5:    v = 12'd512;
            4'd6:    v = 12'd576;
            4'd7:    v = 12'd688;
            4'd8:    v = 12'd944;
            4'd9:    v = 12'd1200;
            4'd10:   v = 12'd1328;
            4'd11:   v = 12'd1360;
            4'd12:   v = 12'd1456;
            4'd13:   v = 12'd1712;
            4'd14:   v = 12'd1904;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/utg_front.sv
// Front end: accepts text bytes, runs the UTF-8 sequence state and pushes
// decoded codepoints into the queue. Depends on utg_pkg.
module utg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             text_byte,
    output logic                   push_valid,
    input  logic                   push_ready,
    output utg_pkg::dec_entry_t    push_data
);

    logic [1:0]                 pending_reg, pending_next;
    logic [utg_pkg::CP_W-1:0]   partial_reg, partial_next;
    logic                       hold_valid_reg, hold_valid_next;
    utg_pkg::dec_entry_t        hold_reg;

    logic                       accept;
    logic                       is_cont;
    logic                       lead_res;
    utg_pkg::dec_entry_t        lead_entry;
    logic [1:0]                 lead_pend;
    logic [utg_pkg::CP_W-1:0]   lead_partial;
    logic                       first_valid;
    logic                       second_valid;
    utg_pkg::dec_entry_t        first_entry;

    // Lead byte decode
    always_comb
    begin
        lead_res     = 1'b1;
        lead_pend    = 2'd0;
        lead_partial = partial_reg;
        lead_entry   = '{cp: '0, malformed: 1'b0, eot: 1'b0, last: 1'b1};
        if (text_byte == 8'h00)
        begin
            lead_entry.eot = 1'b1;
        end
        else if (!text_byte[7])
        begin
            lead_entry.cp = {13'd0, text_byte};
        end
        else if ((text_byte & utg_pkg::LEAD2_MASK) == utg_pkg::LEAD2_PAT)
        begin
            lead_res     = 1'b0;
            lead_pend    = 2'd1;
            lead_partial = {16'd0, text_byte[4:0]};
        end
        else if ((text_byte & utg_pkg::LEAD3_MASK) == utg_pkg::LEAD3_PAT)
        begin
            lead_res     = 1'b0;
            lead_pend    = 2'd2;
            lead_partial = {17'd0, text_byte[3:0]};
        end
        else if ((text_byte & utg_pkg::LEAD4_MASK) == utg_pkg::LEAD4_PAT)
        begin
            lead_res     = 1'b0;
            lead_pend    = 2'd3;
            lead_partial = {18'd0, text_byte[2:0]};
        end
        else
        begin
            lead_entry.cp        = utg_pkg::REPLACEMENT_CP;
            lead_entry.malformed = 1'b1;
        end
    end

    // Sequence state and the results of this byte (none, one or two)
    always_comb
    begin
        is_cont      = (text_byte[7:6] == 2'b10);
        first_valid  = 1'b0;
        second_valid = 1'b0;
        first_entry  = lead_entry;
        pending_next = pending_reg;
        partial_next = partial_reg;
        if (pending_reg != 2'd0 && is_cont)
        begin
            partial_next      = {partial_reg[utg_pkg::CP_W-7:0], text_byte[5:0]};
            pending_next      = pending_reg - 2'd1;
            first_valid       = (pending_reg == 2'd1);
            first_entry       = '{cp: partial_next, malformed: 1'b0, eot: 1'b0, last: 1'b1};
        end
        else if (pending_reg != 2'd0)
        begin
            // broken sequence: replacement, then redo the byte as a lead
            first_valid  = 1'b1;
            second_valid = lead_res;
            first_entry  = '{cp: utg_pkg::REPLACEMENT_CP, malformed: 1'b1, eot: 1'b0,
                             last: !lead_res};
            pending_next = lead_pend;
            partial_next = lead_partial;
        end
        else
        begin
            first_valid  = lead_res;
            pending_next = lead_pend;
            partial_next = lead_partial;
        end
    end

    // Handshakes: a held second result blocks the next byte until it is pushed
    assign in_ready   = !hold_valid_reg && push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = hold_valid_reg || (accept && first_valid);
    assign push_data  = hold_valid_reg ? hold_reg : first_entry;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        else if (accept && second_valid)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 2'd0;
            partial_reg    <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (accept)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
        end
    end

    // Second result payload
    always_ff @(posedge clk)
    begin
        if (accept && second_valid)
        begin
            hold_reg <= lead_entry;
        end
    end

endmodule

>>> hw/rtl/utg_fifo.sv
// Short queue between the decoder front and the lookup back end.
// Depends on utg_pkg.
module utg_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_valid,
    output logic                          push_ready,
    input  utg_pkg::dec_entry_t           push_data,
    output logic                          pop_valid,
    input  logic                          pop_ready,
    output utg_pkg::dec_entry_t           pop_data,
    output logic [utg_pkg::FIFO_AW:0]     level
);

    utg_pkg::dec_entry_t              mem_reg [utg_pkg::FIFO_DEPTH];
    logic [utg_pkg::FIFO_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [utg_pkg::FIFO_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [utg_pkg::FIFO_AW:0]        count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != (utg_pkg::FIFO_AW+1)'(utg_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/utg_back.sv
// Back end: looks up the glyph slot of each queued codepoint across the
// fifteen ranges and holds the result in the output register. Depends on utg_pkg.
module utg_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  utg_pkg::dec_entry_t           pop_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [utg_pkg::CP_W-1:0]      codepoint,
    output logic [utg_pkg::SLOT_W-1:0]    glyph_slot,
    output logic                          in_table,
    output logic                          malformed,
    output logic                          end_of_text,
    output logic                          last
);

    logic                          out_valid_reg, out_valid_next;
    logic [utg_pkg::CP_W-1:0]      cp_reg;
    logic [utg_pkg::SLOT_W-1:0]    slot_reg;
    logic                          hit_reg;
    logic                          bad_reg;
    logic                          eot_reg;
    logic                          last_reg;

    logic                          load;
    logic                          hit;
    logic [utg_pkg::SLOT_W-1:0]    slot;
    logic [utg_pkg::CP_W-1:0]      offset;

    // Range search; ranges are disjoint, lowest index wins
    always_comb
    begin
        hit    = 1'b0;
        slot   = utg_pkg::QMARK_SLOT;
        offset = '0;
        for (int i = utg_pkg::NUM_RANGES - 1; i >= 0; i--)
        begin
            if (pop_data.cp >= utg_pkg::range_first(utg_pkg::RANGE_IW'(i)) &&
                pop_data.cp <  utg_pkg::range_end(utg_pkg::RANGE_IW'(i)))
            begin
                offset = pop_data.cp - utg_pkg::range_first(utg_pkg::RANGE_IW'(i));
                hit    = 1'b1;
                slot   = utg_pkg::range_base(utg_pkg::RANGE_IW'(i)) +
                         offset[utg_pkg::SLOT_W-1:0];
            end
        end
        if (pop_data.eot)
        begin
            hit  = 1'b0;
            slot = '0;
        end
    end

    // Output register, refilled as soon as it is taken
    assign pop_ready = !out_valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= pop_data.cp;
            slot_reg <= slot;
            hit_reg  <= hit;
            bad_reg  <= pop_data.malformed;
            eot_reg  <= pop_data.eot;
            last_reg <= pop_data.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign codepoint   = cp_reg;
    assign glyph_slot  = slot_reg;
    assign in_table    = hit_reg;
    assign malformed   = bad_reg;
    assign end_of_text = eot_reg;
    assign last        = last_reg;

endmodule

>>> hw/rtl/utf8_to_glyph_index_core.sv
// UTF-8 decoder with glyph slot lookup. A byte's result passes through the queue,
// written at the edge that takes the byte, and then the lookup output register.
// Throughput: one byte per cycle without stalls. A byte that breaks an open sequence
// and is no new multibyte lead gives two results and blocks the next byte, as the
// front pushes one entry per cycle. Reset (rst_n low, async): no sequence open,
// queue and output register empty. Depends on utg_pkg, utg_front, utg_fifo, utg_back.
module utf8_to_glyph_index_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [utg_pkg::CP_W-1:0]      codepoint,
    output logic [utg_pkg::SLOT_W-1:0]    glyph_slot,
    output logic                          in_table,
    output logic                          malformed,
    output logic                          end_of_text,
    output logic                          last
);

    logic                          push_valid;
    logic                          push_ready;
    utg_pkg::dec_entry_t           push_data;
    logic                          pop_valid;
    logic                          pop_ready;
    utg_pkg::dec_entry_t           pop_data;
    logic [utg_pkg::FIFO_AW:0]     fifo_level;

    utg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    utg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .level      (fifo_level)
    );

    utg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .codepoint   (codepoint),
        .glyph_slot  (glyph_slot),
        .in_table    (in_table),
        .malformed   (malformed),
        .end_of_text (end_of_text),
        .last        (last)
    );

    // Queue never overfills
    a_fifo_level: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_level <= (utg_pkg::FIFO_AW+1)'(utg_pkg::FIFO_DEPTH))
        else $error("queue level above depth");

    // Terminator carries no glyph
    a_eot_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |->
            codepoint == '0 && glyph_slot == '0 && !in_table && !malformed)
        else $error("terminator result fields wrong");

    // Replacement results fall back to the question mark glyph
    a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && malformed |->
            codepoint == utg_pkg::REPLACEMENT_CP &&
            glyph_slot == utg_pkg::QMARK_SLOT && !in_table)
        else $error("replacement result fields wrong");

    // A miss outside the terminator always maps to the fallback slot
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_table && !end_of_text |-> glyph_slot == utg_pkg::QMARK_SLOT)
        else $error("miss without fallback slot");

endmodule

>>> test/utg_glyph_monitor.sv
// Monitor for the UTF-8 to glyph index core: follows both channels, decodes the
// accepted text bytes itself and checks every result beat against that decode.
// Depends on utg_pkg for field widths, lead byte patterns and fixed codes.
module utg_glyph_monitor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [7:0]                 text_byte,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [utg_pkg::CP_W-1:0]   codepoint,
    input  logic [utg_pkg::SLOT_W-1:0] glyph_slot,
    input  logic                       in_table,
    input  logic                       malformed,
    input  logic                       end_of_text,
    input  logic                       last,
    output int                         mismatch_count,
    output int                         results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         GLYPH_SPANS = 15;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PAT    = 8'h80;

    typedef struct packed {
        logic [utg_pkg::CP_W-1:0]   cp;
        logic [utg_pkg::SLOT_W-1:0] slot;
        logic                       hit;
        logic                       bad;
        logic                       eot;
        logic                       last;
    } glyph_result_t;

    glyph_result_t            glyph_expect_q[$];
    logic [1:0]               conts_left;
    logic [utg_pkg::CP_W-1:0] cp_so_far;

    // First codepoint and length of each baked span, packed back to back
    function automatic int span_first(input int idx);
        case (idx)
            0:       return 'h0020;
            1:       return 'h2000;
            2:       return 'h2070;
            3:       return 'h20A0;
            4:       return 'h2100;
            5:       return 'h2150;
            6:       return 'h2190;
            7:       return 'h2200;
            8:       return 'h2300;
            9:       return 'h2500;
            10:      return 'h2580;
            11:      return 'h25A0;
            12:      return 'h2600;
            13:      return 'h2700;
            default: return 'h2B00;
        endcase
    endfunction

    function automatic int span_len(input int idx);
        case (idx)
            0:       return 'hE0;
            1:       return 'h70;
            2:       return 'h30;
            3:       return 'h30;
            4:       return 'h50;
            5:       return 'h40;
            6:       return 'h70;
            7:       return 'h100;
            8:       return 'h100;
            9:       return 'h80;
            10:      return 'h20;
            11:      return 'h60;
            12:      return 'h100;
            13:      return 'hC0;
            default: return 'h100;
        endcase
    endfunction

    // Build one result: a hit's slot is the running span base plus the offset in its span
    function automatic glyph_result_t glyph_result(input logic [utg_pkg::CP_W-1:0] cp,
                                                   input logic bad, input logic eot);
        glyph_result_t r;
        int            base;
        int            cp_i;
        int            i;
        r.cp   = cp;
        r.slot = eot ? '0 : utg_pkg::QMARK_SLOT;
        r.hit  = 1'b0;
        r.bad  = bad;
        r.eot  = eot;
        r.last = 1'b0;
        base   = 0;
        cp_i   = int'(cp);
        if (!eot) begin
            for (i = 0; i < GLYPH_SPANS; i++) begin
                if (!r.hit && cp_i >= span_first(i) && cp_i < span_first(i) + span_len(i))
                begin
                    r.slot = utg_pkg::SLOT_W'(base + cp_i - span_first(i));
                    r.hit  = 1'b1;
                end
                base += span_len(i);
            end
        end
        return r;
    endfunction

    // Decode one accepted byte and queue the results it gives (none, one or two)
    task automatic decode_text_byte(input logic [7:0] b);
        glyph_result_t res [2];
        int            n;
        int            i;
        n = 0;
        if (conts_left != 0 && (b & CONT_MASK) == CONT_PAT) begin
            cp_so_far  = {cp_so_far[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 0) begin
                res[n] = glyph_result(cp_so_far, 1'b0, 1'b0);
                n++;
            end
        end else begin
            // a broken sequence is replaced, then the byte starts over as a lead
            if (conts_left != 0) begin
                conts_left = 2'd0;
                res[n] = glyph_result(utg_pkg::REPLACEMENT_CP, 1'b1, 1'b0);
                n++;
            end
            if (b == 8'h00) begin
                res[n] = glyph_result('0, 1'b0, 1'b1);
                n++;
            end else if (b[7] == 1'b0) begin
                res[n] = glyph_result({13'd0, b}, 1'b0, 1'b0);
                n++;
            end else if ((b & utg_pkg::LEAD2_MASK) == utg_pkg::LEAD2_PAT) begin
                cp_so_far  = {16'd0, b[4:0]};
                conts_left = 2'd1;
            end else if ((b & utg_pkg::LEAD3_MASK) == utg_pkg::LEAD3_PAT) begin
                cp_so_far  = {17'd0, b[3:0]};
                conts_left = 2'd2;
            end else if ((b & utg_pkg::LEAD4_MASK) == utg_pkg::LEAD4_PAT) begin
                cp_so_far  = {18'd0, b[2:0]};
                conts_left = 2'd3;
            end else begin
                res[n] = glyph_result(utg_pkg::REPLACEMENT_CP, 1'b1, 1'b0);
                n++;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            glyph_expect_q.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare the result beat first: it can never come from a byte taken this edge
    always @(posedge clk or negedge rst_n) begin : watch_channels
        glyph_result_t want;
        if (!rst_n) begin
            glyph_expect_q.delete();
            conts_left     = 2'd0;
            cp_so_far      = '0;
            mismatch_count = 0;
            results_owed   = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (glyph_expect_q.size() == 0) begin
                    $error("result beat with none expected: codepoint %0h", codepoint);
                    mismatch_count++;
                end else begin
                    want = glyph_expect_q.pop_front();
                    check_field("codepoint", want.cp, codepoint);
                    check_field("glyph_slot", want.slot, glyph_slot);
                    check_field("in_table", want.hit, in_table);
                    check_field("malformed", want.bad, malformed);
                    check_field("end_of_text", want.eot, end_of_text);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && in_ready)
                decode_text_byte(text_byte);
            results_owed = glyph_expect_q.size();
        end
    end

endmodule

>>> test/utf8_to_glyph_index_core_tb.sv
// Top of the UTF-8 to glyph index testbench: clock, reset, text byte stimulus,
// random output stalls, watchdog and verdict. Depends on utg_pkg,
// utf8_to_glyph_index_core and utg_glyph_monitor.
module utf8_to_glyph_index_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_BYTES  = 1800;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 20;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic [7:0]                 text_byte = 8'h00;
    logic                       out_ready = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic [utg_pkg::CP_W-1:0]   codepoint;
    logic [utg_pkg::SLOT_W-1:0] glyph_slot;
    logic                       in_table;
    logic                       malformed;
    logic                       end_of_text;
    logic                       last;

    int mismatch_count;
    int results_owed;
    int idle_pct    = 21;
    int stall_pct   = 21;
    int bytes_sent  = 0;
    int quiet_count = 0;

    // Opening text: terminator, ASCII boundary values, bad leads, every sequence length,
    // valid U+FFFD, top codepoint, and sequences broken by ASCII, NUL, bad lead
    // and a fresh lead
    logic [7:0] opening_text [$] = '{
        8'h00, 8'h7F, 8'h1F, 8'h20, 8'hFF, 8'h80,
        8'hC3, 8'hA9,
        8'hEF, 8'hBF, 8'hBD,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hC3, 8'h41,
        8'hE2, 8'h82, 8'h00,
        8'hF0, 8'hFF,
        8'hE2, 8'hC3, 8'hA9
    };

    utf8_to_glyph_index_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .codepoint   (codepoint),
        .glyph_slot  (glyph_slot),
        .in_table    (in_table),
        .malformed   (malformed),
        .end_of_text (end_of_text),
        .last        (last)
    );

    utg_glyph_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .text_byte      (text_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .codepoint      (codepoint),
        .glyph_slot     (glyph_slot),
        .in_table       (in_table),
        .malformed      (malformed),
        .end_of_text    (end_of_text),
        .last           (last),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #5 clk = ~clk;

    // Receiver stalls at random
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: cycles with no beat on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_count <= 0;
        else if (quiet_count >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else
            quiet_count <= quiet_count + 1;
    end

    // One byte beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Encode cp in len bytes and send the first keep of them
    task automatic send_utf8(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        int         i;
        case (len)
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (i = 0; i < keep; i++)
            send_byte(enc[i]);
    endtask

    // Hold the sender off until every queued result has come out
    task automatic wait_results_out();
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial begin : stimulus
        int         kind;
        int         len;
        bit         paused;
        logic [7:0] b;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_text[i])
            send_byte(opening_text[i]);
        wait_results_out();

        // Mostly well-formed text with random content, some broken sequences and noise
        while (bytes_sent < opening_text.size() + TEXT_BYTES) begin
            if (bytes_sent >= 700 && bytes_sent < 1000) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = 21;
                stall_pct = 21;
            end
            if (!paused && bytes_sent >= 400) begin
                paused = 1'b1;
                wait_results_out();
            end
            kind = $urandom_range(99);
            if (kind < 30)
                send_byte(8'($urandom_range(1, 127)));
            else if (kind < 45)
                send_utf8(21'($urandom_range(0, 'h7FF)), 2, 2);
            else if (kind < 55)
                send_utf8(21'($urandom_range('h1FF0, 'h2C0F)), 3, 3);
            else if (kind < 65)
                send_utf8(21'($urandom_range(0, 'hFFFF)), 3, 3);
            else if (kind < 73)
                send_utf8(21'($urandom()), 4, 4);
            else if (kind < 77)
                send_byte(8'h00);
            else if (kind < 90) begin
                // truncated sequence, then a byte that is not a continuation
                len = $urandom_range(2, 4);
                send_utf8(21'($urandom()), len, $urandom_range(1, len - 1));
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                send_byte(b);
            end else
                send_byte(8'($urandom_range(255)));
        end
        in_valid <= 1'b0;

        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/utg_pkg.sv
hw/rtl/utg_front.sv
hw/rtl/utg_fifo.sv
hw/rtl/utg_back.sv
hw/rtl/utf8_to_glyph_index_core.sv
test/utg_glyph_monitor.sv
test/utf8_to_glyph_index_core_tb.sv
